@@ hdl/sor_pkg.sv @@
`default_nettype none

package sor_pkg;

  localparam int FIELD_W     = 11;
  localparam int COORD_W     = 12;
  localparam int RAD_W       = 10;
  localparam int TRIG_W      = 32;
  localparam int FRAC_W      = 30;
  localparam int PROD_W      = 64;
  localparam int SUM_W       = 65;
  localparam int PX_W        = RAD_W + TRIG_W;
  localparam int PIX_W       = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_RECT = 2'd0;
  localparam logic [1:0] CMD_OVAL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // q2.30 trig values
  localparam logic signed [TRIG_W-1:0] Q_ONE    = 32'sd1073741824;
  localparam logic signed [TRIG_W-1:0] COS_STEP = 32'sd1073688137;
  localparam logic signed [TRIG_W-1:0] SIN_STEP = 32'sd10737239;

  // round half away from zero: add half, or half minus one below zero
  localparam logic signed [SUM_W-1:0] RND_POS   = 65'sd536870912;
  localparam logic signed [SUM_W-1:0] RND_NEG   = 65'sd536870911;
  localparam logic signed [PX_W-1:0]  TRUNC_ADJ = 42'sd1073741823;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [RAD_W-1:0]   rad_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef enum logic [1:0] {
    K_RECT,
    K_OVAL,
    K_READ,
    K_NONE
  } kind_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edges_t;

  typedef struct packed {
    kind_t  kind;
    coord_t row;
    coord_t col;
    coord_t row_end;
    coord_t col_end;
    coord_t row_lo;
    coord_t row_hi;
    coord_t col_lo;
    coord_t col_hi;
    logic   row_run;
    logic   col_run;
    edges_t edges;
    rad_t   rx;
    rad_t   ry;
  } entry_t;

  function automatic logic in_image(input coord_t v, input coord_t side);
    return !v[COORD_W-1] && (v < side);
  endfunction

  function automatic coord_t widen(input field_t v);
    return COORD_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ hdl/sor_ram.sv @@
`default_nettype none

module sor_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/sor_front.sv @@
`default_nettype none

module sor_front #(
  parameter int IMAGE_SIDE = 256
) (
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      in_cmd,
  input  sor_pkg::field_t in_row,
  input  sor_pkg::field_t in_col,
  input  sor_pkg::field_t in_shape_height,
  input  sor_pkg::field_t in_shape_width,
  input  logic            q_full,
  input  logic            clearing,
  output logic            push,
  output sor_pkg::entry_t entry
);

  import sor_pkg::*;

  localparam coord_t SIDE_C = coord_t'(IMAGE_SIDE);
  localparam coord_t LAST_C = coord_t'(IMAGE_SIDE - 1);

  coord_t row_w;
  coord_t col_w;
  coord_t h_w;
  coord_t w_w;
  coord_t hx;
  coord_t wx;

  always_comb begin
    row_w = widen(in_row);
    col_w = widen(in_col);
    h_w   = widen(in_shape_height);
    w_w   = widen(in_shape_width);

    // halve toward zero: bump every negative up by one first
    hx = h_w + $signed({{(COORD_W-1){1'b0}}, in_shape_height[FIELD_W-1]});
    wx = w_w + $signed({{(COORD_W-1){1'b0}}, in_shape_width[FIELD_W-1]});

    entry.row     = row_w;
    entry.col     = col_w;
    entry.row_end = row_w + h_w;
    entry.col_end = col_w + w_w;
    entry.rx      = wx[RAD_W:1];
    entry.ry      = hx[RAD_W:1];

    // clipped spans of the outline edges
    entry.col_lo  = col_w[COORD_W-1] ? '0 : col_w;
    entry.col_hi  = (entry.col_end > LAST_C) ? LAST_C : entry.col_end;
    entry.row_lo  = row_w[COORD_W-1] ? '0 : row_w;
    entry.row_hi  = (entry.row_end > LAST_C) ? LAST_C : entry.row_end;
    entry.col_run = entry.col_lo <= entry.col_hi;
    entry.row_run = entry.row_lo <= entry.row_hi;

    entry.edges.top    = in_image(row_w, SIDE_C);
    entry.edges.bottom = in_image(entry.row_end, SIDE_C);
    entry.edges.left   = in_image(col_w, SIDE_C);
    entry.edges.right  = in_image(entry.col_end, SIDE_C);

    case (in_cmd)
      CMD_RECT: begin
        entry.kind = K_RECT;
      end
      CMD_OVAL: begin
        entry.kind = K_OVAL;
      end
      CMD_READ: begin
        entry.kind = (entry.edges.top && entry.edges.left) ? K_READ : K_NONE;
      end
      default: begin
        entry.kind = K_NONE;
      end
    endcase
  end

  assign busy = q_full | clearing;
  assign push = start & ~busy;

endmodule

`default_nettype wire

@@ hdl/sor_queue.sv @@
`default_nettype none

module sor_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sor_pkg::entry_t push_data,
  input  logic            pop,
  output sor_pkg::entry_t pop_data,
  output logic            full,
  output logic            empty
);

  import sor_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10: begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        2'b01: begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign full     = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;

endmodule

`default_nettype wire

@@ hdl/sor_back.sv @@
`default_nettype none

module sor_back #(
  parameter int IMAGE_SIDE  = 256,
  parameter int ANGLE_STEPS = 629
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      empty,
  input  sor_pkg::entry_t           head,
  output logic                      pop,
  output logic                      clearing,
  output logic                      out_valid,
  output logic [sor_pkg::PIX_W-1:0] out_pixel_value,
  output logic                      out_addr_valid
);

  import sor_pkg::*;

  localparam int     DEPTH  = IMAGE_SIDE * IMAGE_SIDE;
  localparam int     ADDR_W = $clog2(DEPTH);
  localparam int     IDX_W  = $clog2(IMAGE_SIDE);
  localparam int     STEP_W = $clog2(ANGLE_STEPS);
  localparam coord_t SIDE_C = coord_t'(IMAGE_SIDE);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RECT_H,
    S_RECT_V,
    S_OVAL_A,
    S_OVAL_B,
    S_READ,
    S_DONE
  } state_t;

  state_t                    state_r,  state_nxt;
  entry_t                    cur_r,    cur_nxt;
  logic [IDX_W-1:0]          idx_r,    idx_nxt;
  logic                      sub_r,    sub_nxt;
  logic [STEP_W-1:0]         k_r,      k_nxt;
  logic [ADDR_W-1:0]         clr_r,    clr_nxt;
  trig_t                     c_r,      c_nxt;
  trig_t                     s_r,      s_nxt;
  logic signed [PROD_W-1:0]  p_cc_r,   p_cc_nxt;
  logic signed [PROD_W-1:0]  p_ss_r,   p_ss_nxt;
  logic signed [PROD_W-1:0]  p_sc_r,   p_sc_nxt;
  logic signed [PROD_W-1:0]  p_cs_r,   p_cs_nxt;
  logic signed [PX_W-1:0]    p_x_r,    p_x_nxt;
  logic signed [PX_W-1:0]    p_y_r,    p_y_nxt;
  logic                      we_r,     we_nxt;
  logic [ADDR_W-1:0]         waddr_r,  waddr_nxt;
  logic                      wdata_r,  wdata_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]          out_pix_r,   out_pix_nxt;
  logic                      out_av_r,    out_av_nxt;

  logic signed [SUM_W-1:0]   v_c;
  logic signed [SUM_W-1:0]   v_s;
  logic signed [SUM_W-1:0]   r_c;
  logic signed [SUM_W-1:0]   r_s;
  logic signed [PX_W-1:0]    t_x;
  logic signed [PX_W-1:0]    t_y;
  coord_t                    pt_x;
  coord_t                    pt_y;

  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [0:0]                ram_rdata;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(c);
  endfunction

  sor_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we_r),
    .waddr(waddr_r),
    .wdata(wdata_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_re    = state_r == S_READ;
  assign ram_raddr = pix_addr(cur_r.row[IDX_W-1:0], cur_r.col[IDX_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    k_nxt         = k_r;
    clr_nxt       = clr_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    p_cc_nxt      = p_cc_r;
    p_ss_nxt      = p_ss_r;
    p_sc_nxt      = p_sc_r;
    p_cs_nxt      = p_cs_r;
    p_x_nxt       = p_x_r;
    p_y_nxt       = p_y_r;
    we_nxt        = 1'b0;
    waddr_nxt     = waddr_r;
    wdata_nxt     = 1'b0;
    out_valid_nxt = 1'b0;
    out_pix_nxt   = out_pix_r;
    out_av_nxt    = out_av_r;
    pop           = 1'b0;

    // rotation update and point of the current angle
    v_c  = SUM_W'(p_cc_r) - SUM_W'(p_ss_r);
    v_s  = SUM_W'(p_sc_r) + SUM_W'(p_cs_r);
    r_c  = v_c + (v_c[SUM_W-1] ? RND_NEG : RND_POS);
    r_s  = v_s + (v_s[SUM_W-1] ? RND_NEG : RND_POS);
    t_x  = p_x_r + (p_x_r[PX_W-1] ? TRUNC_ADJ : '0);
    t_y  = p_y_r + (p_y_r[PX_W-1] ? TRUNC_ADJ : '0);
    pt_x = cur_r.col + $signed(t_x[FRAC_W +: COORD_W]);
    pt_y = cur_r.row + $signed(t_y[FRAC_W +: COORD_W]);

    case (state_r)
      S_CLEAR: begin
        we_nxt    = 1'b1;
        waddr_nxt = clr_r;
        wdata_nxt = 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          sub_nxt = 1'b0;
          case (head.kind)
            K_RECT: begin
              if (head.col_run) begin
                state_nxt = S_RECT_H;
                idx_nxt   = head.col_lo[IDX_W-1:0];
              end else if (head.row_run) begin
                state_nxt = S_RECT_V;
                idx_nxt   = head.row_lo[IDX_W-1:0];
              end else begin
                state_nxt = S_DONE;
              end
            end
            K_OVAL: begin
              state_nxt = S_OVAL_A;
              c_nxt     = Q_ONE;
              s_nxt     = '0;
              k_nxt     = '0;
            end
            K_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // top and bottom edges, one pixel a cycle
      S_RECT_H: begin
        sub_nxt = ~sub_r;
        if (!sub_r) begin
          we_nxt    = cur_r.edges.top;
          waddr_nxt = pix_addr(cur_r.row[IDX_W-1:0], idx_r);
        end else begin
          we_nxt    = cur_r.edges.bottom;
          waddr_nxt = pix_addr(cur_r.row_end[IDX_W-1:0], idx_r);
          if (idx_r == cur_r.col_hi[IDX_W-1:0]) begin
            if (cur_r.row_run) begin
              state_nxt = S_RECT_V;
              idx_nxt   = cur_r.row_lo[IDX_W-1:0];
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      // left and right edges
      S_RECT_V: begin
        sub_nxt = ~sub_r;
        if (!sub_r) begin
          we_nxt    = cur_r.edges.left;
          waddr_nxt = pix_addr(idx_r, cur_r.col[IDX_W-1:0]);
        end else begin
          we_nxt    = cur_r.edges.right;
          waddr_nxt = pix_addr(idx_r, cur_r.col_end[IDX_W-1:0]);
          if (idx_r == cur_r.row_hi[IDX_W-1:0]) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      S_OVAL_A: begin
        p_cc_nxt  = PROD_W'(c_r) * PROD_W'(COS_STEP);
        p_ss_nxt  = PROD_W'(s_r) * PROD_W'(SIN_STEP);
        p_sc_nxt  = PROD_W'(s_r) * PROD_W'(COS_STEP);
        p_cs_nxt  = PROD_W'(c_r) * PROD_W'(SIN_STEP);
        p_x_nxt   = PX_W'(cur_r.rx) * PX_W'(c_r);
        p_y_nxt   = PX_W'(cur_r.ry) * PX_W'(s_r);
        state_nxt = S_OVAL_B;
      end

      S_OVAL_B: begin
        c_nxt     = r_c[FRAC_W +: TRIG_W];
        s_nxt     = r_s[FRAC_W +: TRIG_W];
        we_nxt    = in_image(pt_x, SIDE_C) && in_image(pt_y, SIDE_C);
        waddr_nxt = pix_addr(pt_y[IDX_W-1:0], pt_x[IDX_W-1:0]);
        if (k_r == STEP_W'(ANGLE_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + STEP_W'(1);
          state_nxt = S_OVAL_A;
        end
      end

      S_READ: begin
        state_nxt = S_DONE;
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        case (cur_r.kind)
          K_RECT, K_OVAL: begin
            out_pix_nxt = PIX_BLACK;
            out_av_nxt  = 1'b1;
          end
          K_READ: begin
            out_pix_nxt = ram_rdata[0] ? PIX_WHITE : PIX_BLACK;
            out_av_nxt  = 1'b1;
          end
          default: begin
            out_pix_nxt = PIX_BLACK;
            out_av_nxt  = 1'b0;
          end
        endcase
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      idx_r       <= '0;
      sub_r       <= 1'b0;
      k_r         <= '0;
      we_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      idx_r       <= idx_nxt;
      sub_r       <= sub_nxt;
      k_r         <= k_nxt;
      we_r        <= we_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    c_r       <= c_nxt;
    s_r       <= s_nxt;
    p_cc_r    <= p_cc_nxt;
    p_ss_r    <= p_ss_nxt;
    p_sc_r    <= p_sc_nxt;
    p_cs_r    <= p_cs_nxt;
    p_x_r     <= p_x_nxt;
    p_y_r     <= p_y_nxt;
    waddr_r   <= waddr_nxt;
    wdata_r   <= wdata_nxt;
    out_pix_r <= out_pix_nxt;
    out_av_r  <= out_av_nxt;
  end

  assign clearing        = state_r == S_CLEAR;
  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;
  assign out_addr_valid  = out_av_r;

endmodule

`default_nettype wire

@@ hdl/shape_outline_rasterizer_top.sv @@
`default_nettype none

// One-bit IMAGE_SIDE x IMAGE_SIDE image with rectangle outline, ellipse outline and pixel
// read commands. A command is taken when start is high and busy is low; every command
// gives exactly one result, shown for a single cycle with out_valid, in command order.
// The result port cannot be held off, so sample it whenever out_valid is high.
// After reset all IMAGE_SIDE*IMAGE_SIDE pixels (65536 at the default size) are swept
// white one pixel a cycle, with busy high throughout. A two-entry command queue
// sits in front of the drawing engine, so outside the sweep busy rises only when it is full.
// Work per command: a read looks up its pixel in the image memory; unused or
// out-of-image commands only give their result; a rectangle writes one pixel at a time
// through the single write port of the image memory, top and bottom for each clipped
// column, then left and right for each clipped row; an ellipse takes every angle step
// as the rotation multiply, then its rounding together with the pixel write.
module shape_outline_rasterizer_top #(
  parameter int IMAGE_SIDE  = 256,
  parameter int ANGLE_STEPS = 629
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_cmd,
  input  sor_pkg::field_t           in_row,
  input  sor_pkg::field_t           in_col,
  input  sor_pkg::field_t           in_shape_height,
  input  sor_pkg::field_t           in_shape_width,
  output logic                      out_valid,
  output logic [sor_pkg::PIX_W-1:0] out_pixel_value,
  output logic                      out_addr_valid
);

  import sor_pkg::*;

  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  logic   clearing;

  sor_front #(
    .IMAGE_SIDE(IMAGE_SIDE)
  ) u_front (
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_shape_height(in_shape_height),
    .in_shape_width (in_shape_width),
    .q_full         (q_full),
    .clearing       (clearing),
    .push           (push),
    .entry          (push_entry)
  );

  sor_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_entry),
    .pop      (pop),
    .pop_data (head_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  sor_back #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (q_empty),
    .head           (head_entry),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_pixel_value(out_pixel_value),
    .out_addr_valid (out_addr_valid)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_miss_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_addr_valid) |-> (out_pixel_value == PIX_BLACK))
    else $error("nonzero pixel on an invalid address");

  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("command accepted before image sweep");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command pushed into full queue");

endmodule

`default_nettype wire

@@ tb/sor_checker.sv @@
module sor_checker #(
  parameter int IMAGE_SIDE  = 256,
  parameter int ANGLE_STEPS = 629
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                in_cmd,
  input  sor_pkg::field_t           in_row,
  input  sor_pkg::field_t           in_col,
  input  sor_pkg::field_t           in_shape_height,
  input  sor_pkg::field_t           in_shape_width,
  input  logic                      out_valid,
  input  logic [sor_pkg::PIX_W-1:0] out_pixel_value,
  input  logic                      out_addr_valid,
  output int                        errors,
  output int                        pending,
  output int                        checked,
  output int                        dark_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q30_ONE  = longint'(sor_pkg::Q_ONE);
  localparam longint Q30_HALF = Q30_ONE / 2;
  localparam int     MAX_SHOWN = 200;

  typedef struct packed {
    logic [sor_pkg::PIX_W-1:0] pixel;
    logic                      addr_ok;
  } reply_t;

  bit     canvas [IMAGE_SIDE*IMAGE_SIDE];
  longint cos_q  [ANGLE_STEPS];
  longint sin_q  [ANGLE_STEPS];
  reply_t replies_due [$];
  int     shown;

  function automatic longint round_half_away(input longint v);
    if (v >= 0) return (v + Q30_HALF) / Q30_ONE;
    return -((-v + Q30_HALF) / Q30_ONE);
  endfunction

  function automatic bit on_canvas(input int r, input int c);
    return r >= 0 && r < IMAGE_SIDE && c >= 0 && c < IMAGE_SIDE;
  endfunction

  function automatic void blacken(input int r, input int c);
    if (on_canvas(r, c)) canvas[r*IMAGE_SIDE + c] = 1'b0;
  endfunction

  function automatic void trace_box(input int top, input int left, input int h, input int w);
    int i;
    int j;
    for (j = left; j <= left + w; j++) begin
      blacken(top, j);
      blacken(top + h, j);
    end
    for (i = top; i <= top + h; i++) begin
      blacken(i, left);
      blacken(i, left + w);
    end
  endfunction

  function automatic void trace_oval(input int cy, input int cx, input int h, input int w);
    longint rx;
    longint ry;
    int     k;
    rx = w / 2;
    ry = h / 2;
    // offsets truncate toward zero, as longint division does
    for (k = 0; k < ANGLE_STEPS; k++)
      blacken(cy + int'((ry * sin_q[k]) / Q30_ONE), cx + int'((rx * cos_q[k]) / Q30_ONE));
  endfunction

  function automatic reply_t apply_command(input logic [1:0] op, input int r, input int c,
                                           input int h, input int w);
    reply_t rep;
    rep = '0;
    case (op)
      sor_pkg::CMD_RECT: begin
        trace_box(r, c, h, w);
        rep.addr_ok = 1'b1;
      end
      sor_pkg::CMD_OVAL: begin
        trace_oval(r, c, h, w);
        rep.addr_ok = 1'b1;
      end
      sor_pkg::CMD_READ: begin
        if (on_canvas(r, c)) begin
          rep.addr_ok = 1'b1;
          rep.pixel   = canvas[r*IMAGE_SIDE + c] ? sor_pkg::PIX_WHITE : sor_pkg::PIX_BLACK;
          if (!canvas[r*IMAGE_SIDE + c]) dark_reads++;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    if (shown < MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    shown++;
  endtask

  // rotation recurrence for the q2.30 cosine and sine tables
  initial begin
    longint c;
    longint s;
    longint nc;
    c = Q30_ONE;
    s = 0;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      cos_q[k] = c;
      sin_q[k] = s;
      nc = round_half_away(c * longint'(sor_pkg::COS_STEP) - s * longint'(sor_pkg::SIN_STEP));
      s  = round_half_away(s * longint'(sor_pkg::COS_STEP) + c * longint'(sor_pkg::SIN_STEP));
      c  = nc;
    end
    for (int p = 0; p < IMAGE_SIDE*IMAGE_SIDE; p++) canvas[p] = 1'b1;
  end

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst_n) begin
      // compare first so a stray result never meets a request taken this edge
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (shown < MAX_SHOWN)
            $display("%0t: unexpected result: expected none, got pixel %0d addr_valid %0d",
                     $time, out_pixel_value, out_addr_valid);
          shown++;
        end else begin
          want = replies_due.pop_front();
          checked++;
          if (out_pixel_value !== want.pixel)
            note_mismatch("pixel_value", want.pixel, out_pixel_value);
          if (out_addr_valid !== want.addr_ok)
            note_mismatch("addr_valid", want.addr_ok, out_addr_valid);
        end
      end
      if (start && !busy)
        replies_due.push_back(apply_command(in_cmd, in_row, in_col, in_shape_height,
                                            in_shape_width));
    end
    pending = replies_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMAGE_SIDE   = 256;
  localparam int ANGLE_STEPS  = 629;
  localparam int CLK_PERIOD   = 20;
  localparam int STALL_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 2*ANGLE_STEPS + 40;
  localparam int PHASE_ITEMS  = 180;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_cmd = sor_pkg::CMD_READ;
  sor_pkg::field_t           in_row = '0;
  sor_pkg::field_t           in_col = '0;
  sor_pkg::field_t           in_shape_height = '0;
  sor_pkg::field_t           in_shape_width = '0;
  logic                      out_valid;
  logic [sor_pkg::PIX_W-1:0] out_pixel_value;
  logic                      out_addr_valid;

  int errors;
  int pending;
  int checked;
  int dark_reads;

  int idle_pct;
  int quiet;
  int n_rect;
  int n_oval;
  int n_read;
  int n_unused;

  logic [1:0] last_op = sor_pkg::CMD_RECT;
  int last_row;
  int last_col;
  int last_h;
  int last_w;

  always #(CLK_PERIOD/2) clk = ~clk;

  shape_outline_rasterizer_top #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .ANGLE_STEPS(ANGLE_STEPS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_shape_height(in_shape_height),
    .in_shape_width (in_shape_width),
    .out_valid      (out_valid),
    .out_pixel_value(out_pixel_value),
    .out_addr_valid (out_addr_valid)
  );

  sor_checker #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_shape_height(in_shape_height),
    .in_shape_width (in_shape_width),
    .out_valid      (out_valid),
    .out_pixel_value(out_pixel_value),
    .out_addr_valid (out_addr_valid),
    .errors         (errors),
    .pending        (pending),
    .checked        (checked),
    .dark_reads     (dark_reads)
  );

  // covers the white sweep after reset as well as the longest ellipse
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("%0t: watchdog: nothing moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int rand_field();
    return int'(sor_pkg::field_t'($urandom));
  endfunction

  // entered and left at a falling edge; start stays high for a back-to-back request
  task automatic send_request(input logic [1:0] op, input int r, input int c,
                              input int h, input int w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= op;
    in_row          <= sor_pkg::field_t'(r);
    in_col          <= sor_pkg::field_t'(c);
    in_shape_height <= sor_pkg::field_t'(h);
    in_shape_width  <= sor_pkg::field_t'(w);
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    case (op)
      sor_pkg::CMD_RECT: n_rect++;
      sor_pkg::CMD_OVAL: n_oval++;
      sor_pkg::CMD_READ: n_read++;
      default:           n_unused++;
    endcase
    if (op == sor_pkg::CMD_RECT || op == sor_pkg::CMD_OVAL) begin
      last_op  = op;
      last_row = r;
      last_col = c;
      last_h   = h;
      last_w   = w;
    end
  endtask

  // always lets at least one falling edge pass with start low
  task automatic drain_replies();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // reads mostly land on the outline of the last shape drawn
  task automatic send_read();
    int r;
    int c;
    int along_r;
    int along_c;
    int k;
    case ($urandom_range(9))
      0: begin
        r = rand_field();
        c = rand_field();
      end
      1, 2: begin
        r = $urandom_range(IMAGE_SIDE-1);
        c = $urandom_range(IMAGE_SIDE-1);
      end
      default: begin
        if (last_op == sor_pkg::CMD_RECT) begin
          along_r = last_row + (last_h > 0 ? $urandom_range(last_h) : 0);
          along_c = last_col + (last_w > 0 ? $urandom_range(last_w) : 0);
          case ($urandom_range(3))
            0: begin r = last_row;          c = along_c;           end
            1: begin r = last_row + last_h; c = along_c;           end
            2: begin r = along_r;           c = last_col;          end
            default: begin r = along_r;     c = last_col + last_w; end
          endcase
        end else begin
          k = $urandom_range(ANGLE_STEPS-1);
          r = last_row + $rtoi((last_h / 2) * $sin(k * 0.01));
          c = last_col + $rtoi((last_w / 2) * $cos(k * 0.01));
        end
        if ($urandom_range(3) == 0) r = r + $urandom_range(2) - 1;
      end
    endcase
    send_request(sor_pkg::CMD_READ, r, c, rand_field(), rand_field());
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_read();
    end else if (pick < 65) begin
      if ($urandom_range(99) < 15)
        send_request(sor_pkg::CMD_RECT, rand_field(), rand_field(), rand_field(), rand_field());
      else
        send_request(sor_pkg::CMD_RECT, $urandom_range(IMAGE_SIDE+39) - 20,
                     $urandom_range(IMAGE_SIDE+39) - 20, $urandom_range(64) - 4,
                     $urandom_range(64) - 4);
    end else if (pick < 95) begin
      if ($urandom_range(99) < 15)
        send_request(sor_pkg::CMD_OVAL, rand_field(), rand_field(), rand_field(), rand_field());
      else
        send_request(sor_pkg::CMD_OVAL, $urandom_range(IMAGE_SIDE+39) - 20,
                     $urandom_range(IMAGE_SIDE+39) - 20, $urandom_range(310) - 10,
                     $urandom_range(310) - 10);
    end else begin
      send_request(CMD_UNUSED, rand_field(), rand_field(), rand_field(), rand_field());
    end
  endtask

  initial begin
    int phase_idle [3];
    phase_idle = '{27, 68, 0};
    idle_pct = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // image starts white; reads on the corners, far outside, and just off the bottom and left borders
    send_request(sor_pkg::CMD_READ, 0, 0, 0, 0);
    send_request(sor_pkg::CMD_READ, IMAGE_SIDE-1, IMAGE_SIDE-1, 1023, 1023);
    send_request(sor_pkg::CMD_READ, -1024, -1024, -1024, -1024);
    send_request(sor_pkg::CMD_READ, 1023, 1023, 1023, -1024);
    send_request(sor_pkg::CMD_READ, IMAGE_SIDE, 0, -1024, 1023);
    send_request(sor_pkg::CMD_READ, 0, -1, 0, 0);
    // full border: bottom edge sits on the last row
    send_request(sor_pkg::CMD_RECT, 0, 0, IMAGE_SIDE-1, IMAGE_SIDE-1);
    send_request(sor_pkg::CMD_READ, IMAGE_SIDE-1, 100, 0, 0);
    send_request(sor_pkg::CMD_READ, 100, IMAGE_SIDE-1, 0, 0);
    // negative extents leave out the edges that run along them
    send_request(sor_pkg::CMD_RECT, 10, 20, 5, -3);
    send_request(sor_pkg::CMD_READ, 12, 20, 0, 0);
    send_request(sor_pkg::CMD_RECT, 40, 40, -2, 6);
    send_request(sor_pkg::CMD_RECT, -1024, -1024, 1023, 1023);
    send_request(sor_pkg::CMD_RECT, 1023, 1023, -1024, -1024);
    send_request(sor_pkg::CMD_OVAL, 128, 128, 200, 100);
    send_request(sor_pkg::CMD_READ, 128, 178, 0, 0);
    // ellipse centred at row zero, column zero
    send_request(sor_pkg::CMD_OVAL, 0, 0, 100, 100);
    send_request(sor_pkg::CMD_READ, 0, 50, 0, 0);
    send_request(sor_pkg::CMD_OVAL, 1023, 1023, 1023, 1023);
    send_request(sor_pkg::CMD_OVAL, -1024, -1024, -1024, -1024);
    send_request(sor_pkg::CMD_OVAL, 100, 100, -7, -9);
    send_request(CMD_UNUSED, 1023, -1024, 1023, -1024);
    send_request(CMD_UNUSED, -1024, 1023, -1024, 1023);
    send_request(sor_pkg::CMD_READ, 128, 128, 0, 0);
    drain_replies();

    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      repeat (PHASE_ITEMS) begin
        send_random();
        if ($urandom_range(49) == 0) drain_replies();
      end
      drain_replies();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("requests: %0d rectangles, %0d ellipses, %0d reads, %0d unused commands",
             n_rect, n_oval, n_read, n_unused);
    $display("%0d results checked, %0d reads hit a painted pixel", checked, dark_reads);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sor_pkg.sv
hdl/sor_ram.sv
hdl/sor_front.sv
hdl/sor_queue.sv
hdl/sor_back.sv
hdl/shape_outline_rasterizer_top.sv
tb/sor_checker.sv
tb/tb_top.sv
